/* hdl/filled_circle_rasterizer_defines.svh */
// assertion macros shared by the rasterizer rtl
`ifndef FILLED_CIRCLE_RASTERIZER_DEFINES_SVH
`define FILLED_CIRCLE_RASTERIZER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FCR_ASSERT_HOLD(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcr check failed: same-cycle implication");

// next-cycle implication, sampled on clk_i, off during reset
`define FCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcr check failed: next-cycle implication");

`endif

/* hdl/fcr_pkg.sv */
package fcr_pkg;

  // width of a packed pixel color word
  localparam int unsigned COLOR_W = 32;

  // input item kinds
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  // configuration register indexes
  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

/* hdl/filled_circle_rasterizer.sv */
// Filled circle rasterizer. A start transfer loads center, radius and color and
// arms a scan of the circle's bounding box, x outer and y inner, both ascending.
// Every later step transfer of an armed scan visits one box position and yields
// one result: a framebuffer write (vertically flipped word offset and the held
// color) when the position is inside the circle and the frame, otherwise an
// empty result; the final box position raises last. Every input transfer, start
// or step, yields exactly one result. Throughput is one item per clock while
// in_stall_o is low: the circle test (two squares and a compare) and the address
// multiply sit between the scan state and the output buffer. A two-entry output
// buffer lets one more item in while a result is held back by out_stall_i;
// in_stall_o rises only when both entries are full. The user must write frame
// size registers through the config port only while idle; it is not enforced.
`include "filled_circle_rasterizer_defines.svh"

module filled_circle_rasterizer #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12,
  parameter int DIM_BITS    = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [DIM_BITS:0]             cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_action_i,
  input  logic signed [COORD_BITS-1:0]  in_center_x_i,
  input  logic signed [COORD_BITS-1:0]  in_center_y_i,
  input  logic [RADIUS_BITS-1:0]        in_radius_i,
  input  logic [fcr_pkg::COLOR_W-1:0]   in_color_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_write_enable_o,
  output logic [2*DIM_BITS-1:0]         out_pixel_address_o,
  output logic [fcr_pkg::COLOR_W-1:0]   out_pixel_color_o,
  output logic                          out_last_o
);

  localparam int DIM_W  = DIM_BITS + 1;
  localparam int ADDR_W = 2 * DIM_BITS;
  localparam int SQ_W   = 2 * RADIUS_BITS;
  localparam int SCAN_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS + 1) + 1;
  localparam int CMP_W  = (SCAN_W > DIM_BITS + 2) ? SCAN_W : DIM_BITS + 2;
  localparam int DIM_TOP = 2 ** DIM_BITS;
  localparam int FW_RST  = (640 > DIM_TOP) ? DIM_TOP : 640;
  localparam int FH_RST  = (480 > DIM_TOP) ? DIM_TOP : 480;
  localparam logic [DIM_W-1:0] DIM_MAX = {1'b1, {DIM_BITS{1'b0}}};

  typedef struct packed {
    logic                        write_enable;
    logic [ADDR_W-1:0]           addr;
    logic [fcr_pkg::COLOR_W-1:0] color;
    logic                        last;
  } result_t;

  // frame size registers
  logic [DIM_W-1:0] fw_q, fh_q;
  logic [DIM_W-1:0] cfg_clamped;

  assign cfg_clamped = (cfg_data_i > DIM_MAX) ? DIM_MAX : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= DIM_W'(FW_RST);
      fh_q <= DIM_W'(FH_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcr_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_clamped;
        fcr_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // scan state
  logic                          active_q;
  logic signed [COORD_BITS-1:0]  cx_q, cy_q;
  logic [SQ_W-1:0]               rsq_q;
  logic [fcr_pkg::COLOR_W-1:0]   color_q;
  logic signed [SCAN_W-1:0]      scan_x_q, scan_y_q;
  logic signed [SCAN_W-1:0]      y_first_q, y_last_q, x_last_q;

  logic in_acc;
  logic is_step;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign is_step = (in_action_i == fcr_pkg::ACT_STEP);

  // center and radius of a new circle, widened to the scan width
  logic signed [SCAN_W-1:0] new_cx, new_cy, new_r;
  assign new_cx = SCAN_W'(in_center_x_i);
  assign new_cy = SCAN_W'(in_center_y_i);
  assign new_r  = $signed(SCAN_W'(in_radius_i));

  // circle test on the current position
  logic signed [SCAN_W-1:0]          dx_full, dy_full;
  logic signed [RADIUS_BITS:0]       dx, dy;
  logic signed [2*RADIUS_BITS+1:0]   dx_sq, dy_sq;
  logic [SQ_W:0]                     dist_sq;
  logic                              in_circle;

  assign dx_full   = scan_x_q - SCAN_W'(cx_q);
  assign dy_full   = scan_y_q - SCAN_W'(cy_q);
  assign dx        = dx_full[RADIUS_BITS:0];
  assign dy        = dy_full[RADIUS_BITS:0];
  assign dx_sq     = (2*RADIUS_BITS+2)'(dx) * (2*RADIUS_BITS+2)'(dx);
  assign dy_sq     = (2*RADIUS_BITS+2)'(dy) * (2*RADIUS_BITS+2)'(dy);
  assign dist_sq   = {1'b0, dx_sq[SQ_W-1:0]} + {1'b0, dy_sq[SQ_W-1:0]};
  assign in_circle = (dist_sq <= {1'b0, rsq_q});

  // frame clip
  logic signed [CMP_W-1:0] x_ext, y_ext, fw_ext, fh_ext;
  logic                    in_frame;

  assign x_ext    = CMP_W'(scan_x_q);
  assign y_ext    = CMP_W'(scan_y_q);
  assign fw_ext   = $signed(CMP_W'(fw_q));
  assign fh_ext   = $signed(CMP_W'(fh_q));
  assign in_frame = !x_ext[CMP_W-1] && !y_ext[CMP_W-1] && (x_ext < fw_ext) && (y_ext < fh_ext);

  // flipped word offset
  logic [DIM_W-1:0]  row_full;
  logic [DIM_BITS-1:0] row;
  logic [ADDR_W:0]   addr_prod, addr_sum;

  assign row_full  = fh_q - DIM_W'(y_ext[DIM_BITS-1:0]) - DIM_W'(1);
  assign row       = row_full[DIM_BITS-1:0];
  assign addr_prod = (ADDR_W + 1)'(row) * (ADDR_W + 1)'(fw_q);
  assign addr_sum  = addr_prod + (ADDR_W + 1)'(x_ext[DIM_BITS-1:0]);

  // end of column and end of box
  logic y_end, x_end;
  assign y_end = (scan_y_q == y_last_q);
  assign x_end = (scan_x_q == x_last_q);

  // result of this item
  result_t res_new;
  logic    draw;

  always_comb begin
    res_new = '0;
    draw    = is_step && active_q && in_circle && in_frame;
    if (draw) begin
      res_new.write_enable = 1'b1;
      res_new.addr         = addr_sum[ADDR_W-1:0];
      res_new.color        = color_q;
    end
    res_new.last = is_step && active_q && x_end && y_end;
  end

  // scan state update on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (in_acc) begin
      if (!is_step) begin
        active_q <= 1'b1;
      end else if (active_q && x_end && y_end) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!is_step) begin
        cx_q      <= in_center_x_i;
        cy_q      <= in_center_y_i;
        rsq_q     <= SQ_W'(in_radius_i) * SQ_W'(in_radius_i);
        color_q   <= in_color_i;
        scan_x_q  <= new_cx - new_r;
        scan_y_q  <= new_cy - new_r;
        y_first_q <= new_cy - new_r;
        y_last_q  <= new_cy + new_r;
        x_last_q  <= new_cx + new_r;
      end else if (active_q && !(x_end && y_end)) begin
        if (y_end) begin
          scan_y_q <= y_first_q;
          scan_x_q <= scan_x_q + SCAN_W'(1);
        end else begin
          scan_y_q <= scan_y_q + SCAN_W'(1);
        end
      end
    end
  end

  // two-entry output buffer: result register plus skid
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_fire;

  assign out_fire   = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_write_enable_o  = out_q.write_enable;
  assign out_pixel_address_o = out_q.addr;
  assign out_pixel_color_o   = out_q.color;
  assign out_last_o          = out_q.last;

  // checks
  `FCR_ASSERT_HOLD(a_skid_needs_out, skid_valid_q, out_valid_q)
  `FCR_ASSERT_NEXT(a_skid_fills, in_acc && out_valid_q && out_stall_i, skid_valid_q)
  `FCR_ASSERT_NEXT(a_start_arms, in_acc && !is_step, active_q)
  `FCR_ASSERT_HOLD(a_empty_result_zero, out_valid_q && !out_q.write_enable,
                   out_q.addr == '0 && out_q.color == '0)
  `FCR_ASSERT_HOLD(a_scan_y_in_box, active_q,
                   scan_y_q >= y_first_q && scan_y_q <= y_last_q)

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

  // one transfer on the input channel
  typedef struct packed {
    fcr_pkg::action_e action;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [11:0] r;
    logic [31:0] color;
  } circle_cmd_t;

  // one framebuffer write result
  typedef struct packed {
    logic        we;
    logic [23:0] addr;
    logic [31:0] color;
    logic        last;
  } pixel_wr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        in_action_i = 1'b0;
  logic [15:0] in_center_x_i = '0;
  logic [15:0] in_center_y_i = '0;
  logic [11:0] in_radius_i = '0;
  logic [31:0] in_color_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_write_enable_o;
  logic [23:0] out_pixel_address_o;
  logic [31:0] out_pixel_color_o;
  logic        out_last_o;

  filled_circle_rasterizer DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_action_i        (in_action_i),
    .in_center_x_i      (in_center_x_i),
    .in_center_y_i      (in_center_y_i),
    .in_radius_i        (in_radius_i),
    .in_color_i         (in_color_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_write_enable_o (out_write_enable_o),
    .out_pixel_address_o(out_pixel_address_o),
    .out_pixel_color_o  (out_pixel_color_o),
    .out_last_o         (out_last_o)
  );

  circle_cmd_t cmd_q[$];
  circle_cmd_t bus_cmd;
  pixel_wr_t   pixels_due[$];

  int idle_pct = 29;
  int n_queued = 0;
  int n_accepted = 0;
  int n_starts = 0;
  int n_writes = 0;
  int n_finished = 0;
  int n_sizes = 1;
  int err_count = 0;

  // rasterizer shadow state
  logic   scan_on = 1'b0;
  longint hold_cx = 0;
  longint hold_cy = 0;
  longint hold_r = 0;
  logic [31:0] hold_color = '0;
  longint scan_col = 0;
  longint scan_row = 0;
  longint frame_w = 640;
  longint frame_h = 480;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // advance the shadow rasterizer by one input transfer
  function automatic pixel_wr_t raster_step(circle_cmd_t c);
    pixel_wr_t px;
    longint    dx, dy, row;
    logic      hit, on_frame, row_end, col_end;
    px = '0;
    if (c.action == fcr_pkg::ACT_START) begin
      hold_cx = longint'($signed(c.cx));
      hold_cy = longint'($signed(c.cy));
      hold_r = longint'(c.r);
      hold_color = c.color;
      scan_col = hold_cx - hold_r;
      scan_row = hold_cy - hold_r;
      scan_on = 1'b1;
    end else if (scan_on) begin
      dx = scan_col - hold_cx;
      dy = scan_row - hold_cy;
      hit = (dx * dx + dy * dy) <= hold_r * hold_r;
      on_frame = scan_col >= 0 && scan_row >= 0 &&
                 scan_col < frame_w && scan_row < frame_h;
      if (hit && on_frame) begin
        // rows are flipped so y = 0 lands on the bottom line
        row = frame_h - scan_row - 1;
        px.we = 1'b1;
        px.addr = 24'(row * frame_w + scan_col);
        px.color = hold_color;
      end
      row_end = scan_row == hold_cy + hold_r;
      col_end = scan_col == hold_cx + hold_r;
      if (row_end && col_end) begin
        px.last = 1'b1;
        scan_on = 1'b0;
      end else if (row_end) begin
        scan_row = hold_cy - hold_r;
        scan_col = scan_col + 1;
      end else begin
        scan_row = scan_row + 1;
      end
    end
    return px;
  endfunction

  task automatic flag_error(string what, pixel_wr_t want, pixel_wr_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t %s: expected we=%0b addr=%06h color=%08h last=%0b",
               $realtime, what, want.we, want.addr, want.color, want.last);
      $display("    got we=%0b addr=%06h color=%08h last=%0b",
               got.we, got.addr, got.color, got.last);
    end
  endtask

  task automatic add_steps(int n);
    circle_cmd_t c;
    repeat (n) begin
      // step transfers carry random junk in the unused fields
      c.action = fcr_pkg::ACT_STEP;
      c.cx = 16'($urandom);
      c.cy = 16'($urandom);
      c.r = 12'($urandom);
      c.color = $urandom;
      cmd_q.push_back(c);
      n_queued++;
    end
  endtask

  task automatic add_circle(int cx, int cy, int r, logic [31:0] col, int nsteps);
    circle_cmd_t c;
    c.action = fcr_pkg::ACT_START;
    c.cx = cx[15:0];
    c.cy = cy[15:0];
    c.r = r[11:0];
    c.color = col;
    cmd_q.push_back(c);
    n_queued++;
    add_steps(nsteps);
  endtask

  // register write through the config port, shadow updated alongside
  task automatic write_frame(fcr_pkg::cfg_reg_e idx, int unsigned val);
    logic [12:0] v;
    longint      sat;
    v = val[12:0];
    sat = (v > 13'd4096) ? 4096 : longint'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fcr_pkg::CFG_FRAME_WIDTH)
      frame_w = sat;
    else
      frame_h = sat;
  endtask

  // wait until every queued transfer went in and every result came out
  task automatic drain(int settle);
    while (n_accepted != n_queued || pixels_due.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // random circles, mostly complete scans in or near the frame
  task automatic fill_random(int budget);
    int added, pick, r, cx, cy, w, h, nsteps, full, sel;
    added = 0;
    w = int'(frame_w);
    h = int'(frame_h);
    while (added < budget) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        add_steps($urandom_range(1, 3));
      end else if (pick < 9) begin
        // huge box, only the opening part of the scan is walked
        r = $urandom_range(1) ? 4095 : $urandom_range(9, 4095);
        cx = int'($urandom_range(65535)) - 32768;
        cy = int'($urandom_range(65535)) - 32768;
        nsteps = $urandom_range(1, 40);
        add_circle(cx, cy, r, $urandom, nsteps);
        added += 1 + nsteps;
      end else begin
        r = ($urandom_range(3) != 0) ? $urandom_range(0, 4) : $urandom_range(5, 8);
        sel = $urandom_range(9);
        if (sel == 0) begin
          cx = int'($urandom_range(65535)) - 32768;
          cy = int'($urandom_range(65535)) - 32768;
        end else if (sel < 5) begin
          cx = ($urandom_range(1) ? 0 : w - 1) + int'($urandom_range(2 * r + 2)) - r - 1;
          cy = ($urandom_range(1) ? 0 : h - 1) + int'($urandom_range(2 * r + 2)) - r - 1;
        end else begin
          cx = int'($urandom_range(w + 2 * r + 1)) - r - 1;
          cy = int'($urandom_range(h + 2 * r + 1)) - r - 1;
        end
        full = (2 * r + 1) * (2 * r + 1);
        nsteps = ($urandom_range(9) == 0) ? $urandom_range(0, full - 1) : full;
        add_circle(cx, cy, r, $urandom, nsteps);
        added += 1 + nsteps;
      end
    end
  endtask

  // input driver
  always @(posedge clk_i) begin : drive_proc
    logic      moved;
    pixel_wr_t px;
    moved = in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (moved) begin
        px = raster_step(bus_cmd);
        pixels_due.push_back(px);
        n_accepted++;
        if (bus_cmd.action == fcr_pkg::ACT_START) n_starts++;
        if (px.we) n_writes++;
        if (px.last) n_finished++;
      end
      if (!in_valid_i || moved) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          bus_cmd = cmd_q.pop_front();
          in_valid_i <= 1'b1;
          in_action_i <= bus_cmd.action;
          in_center_x_i <= bus_cmd.cx;
          in_center_y_i <= bus_cmd.cy;
          in_radius_i <= bus_cmd.r;
          in_color_i <= bus_cmd.color;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i) begin : check_proc
    pixel_wr_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.we = out_write_enable_o;
        got.addr = out_pixel_address_o;
        got.color = out_pixel_color_o;
        got.last = out_last_o;
        if (pixels_due.size() == 0) begin
          flag_error("unexpected result", '0, got);
        end else begin
          want = pixels_due.pop_front();
          if (got.we !== want.we || got.addr !== want.addr ||
              got.color !== want.color || got.last !== want.last)
            flag_error("result mismatch", want, got);
        end
      end
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin : stim_proc
    int ph;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default frame: idle steps, single pixel, clipped corners, abandoned scans
    add_steps(1);
    add_circle(5, 7, 0, 32'h00ff00ff, 1);
    add_circle(0, 0, 1, 32'hffffffff, 9);
    add_steps(1);
    add_circle(-32768, 32767, 4095, 32'h00000000, 2);
    add_circle(32767, -32768, 4095, 32'ha5a5a5a5, 1);
    add_circle(639, 479, 1, 32'h5a5a5a5a, 9);
    add_steps(1);
    fill_random(220);
    drain(4);

    // smallest non-empty frame
    write_frame(fcr_pkg::CFG_FRAME_WIDTH, 1);
    write_frame(fcr_pkg::CFG_FRAME_HEIGHT, 1);
    n_sizes++;
    fill_random(150);
    drain(4);

    // largest frame, top address corner
    write_frame(fcr_pkg::CFG_FRAME_WIDTH, 4096);
    write_frame(fcr_pkg::CFG_FRAME_HEIGHT, 4096);
    n_sizes++;
    add_circle(4095, 0, 1, 32'h12345678, 9);
    add_circle(0, 4095, 0, 32'hedcba987, 1);
    fill_random(220);
    drain(4);

    // zero width clips everything
    write_frame(fcr_pkg::CFG_FRAME_WIDTH, 0);
    write_frame(fcr_pkg::CFG_FRAME_HEIGHT, 300);
    n_sizes++;
    fill_random(120);
    drain(4);

    // oversized values saturate
    write_frame(fcr_pkg::CFG_FRAME_WIDTH, 8191);
    write_frame(fcr_pkg::CFG_FRAME_HEIGHT, 5000);
    n_sizes++;
    fill_random(200);
    drain(4);

    // random frames, one phase with no idling on either side
    for (ph = 0; ph < 5; ph++) begin
      idle_pct = (ph == 2) ? 0 : 29;
      write_frame(fcr_pkg::CFG_FRAME_WIDTH,
                  $urandom_range(1) ? $urandom_range(1, 64) : $urandom_range(1, 4096));
      write_frame(fcr_pkg::CFG_FRAME_HEIGHT,
                  $urandom_range(1) ? $urandom_range(1, 64) : $urandom_range(1, 4096));
      n_sizes++;
      fill_random(220);
      drain(4);
    end
    drain(8);

    if (pixels_due.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", pixels_due.size());
    end
    $display("drove %0d transfers over %0d frame sizes: %0d circles, %0d scans finished",
             n_accepted, n_sizes, n_starts, n_finished);
    $display("%0d pixel writes predicted, %0d errors", n_writes, err_count);
    if (err_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

/* filled_circle_rasterizer.f */
+incdir+hdl
hdl/fcr_pkg.sv
hdl/filled_circle_rasterizer.sv
tb/sv/tb.sv
